### src/kst_pkg.sv
`default_nettype none
package kst_pkg;

  // Keyboard and string store dimensions.
  localparam int NUM_KEYS     = 83;
  localparam int ROM_ROWS     = 83;
  localparam int NUM_FKEYS    = 8;
  localparam int FKEY_MAX_LEN = 8;
  localparam int MAX_OUT      = 8;

  localparam int FKEY_CAP     = (FKEY_MAX_LEN < MAX_OUT) ? FKEY_MAX_LEN : MAX_OUT;
  localparam int FKEY_IDX_W   = (NUM_FKEYS > 1) ? $clog2(NUM_FKEYS) : 1;
  localparam int FKEY_OFS_W   = $clog2(FKEY_MAX_LEN);
  localparam int STORE_DEPTH  = NUM_FKEYS * FKEY_MAX_LEN;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int FKEY_LEN_W   = 4;
  localparam int CNT_W        = $clog2(MAX_OUT + 1);

  // Byte codes.
  localparam logic [7:0] ESC_CODE   = 8'h1b;
  localparam logic [7:0] BREAK_CODE = 8'h80;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7a;
  localparam logic [7:0] CASE_DIFF  = 8'd32;
  localparam logic [FKEY_LEN_W-1:0] FKEY_DEF_LEN = 4'd2;

  // Special key numbers.
  localparam logic [6:0] KEY_SET_UP  = 7'd1;
  localparam logic [6:0] KEY_CONTROL = 7'd2;
  localparam logic [6:0] KEY_CAPS    = 7'd3;
  localparam logic [6:0] KEY_RSHIFT  = 7'd4;
  localparam logic [6:0] KEY_LSHIFT  = 7'd5;

  // Code ROM columns.
  localparam logic [1:0] COL_NORMAL     = 2'd0;
  localparam logic [1:0] COL_SHIFT      = 2'd1;
  localparam logic [1:0] COL_CTRL       = 2'd2;
  localparam logic [1:0] COL_CTRL_SHIFT = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIRECT,
    ST_READ,
    ST_EMIT
  } kst_state_t;

  // Read request into the function-key string store.
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
  } kst_rd_req_t;

  // One row of the code ROM, normal column in the top byte.
  function automatic logic [31:0] code_row(input logic [6:0] key);
    logic [31:0] row;
    unique case (key)
      7'd0:  row = 32'h80808080;
      7'd1:  row = 32'hffffffff;
      7'd2:  row = 32'hffffffff;
      7'd3:  row = 32'hffffffff;
      7'd4:  row = 32'hffffffff;
      7'd5:  row = 32'hffffffff;
      7'd6:  row = 32'h1b1b1b1b;
      7'd7:  row = 32'h31213121;
      7'd8:  row = 32'h09090909;
      7'd9:  row = 32'h71511111;
      7'd10: row = 32'h61410101;
      7'd11: row = 32'h73531313;
      7'd12: row = 32'hffffffff;
      7'd13: row = 32'h32403200;
      7'd14: row = 32'h33233323;
      7'd15: row = 32'h77571717;
      7'd16: row = 32'h65450505;
      7'd17: row = 32'h64440404;
      7'd18: row = 32'h66460606;
      7'd19: row = 32'h7a5a1a1a;
      7'd20: row = 32'h78581818;
      7'd21: row = 32'h34243424;
      7'd22: row = 32'h35253525;
      7'd23: row = 32'h72521212;
      7'd24: row = 32'h74541414;
      7'd25: row = 32'h67470707;
      7'd26: row = 32'h68480808;
      7'd27: row = 32'h63430303;
      7'd28: row = 32'h76561616;
      7'd29: row = 32'h365e361e;
      7'd30: row = 32'h37263726;
      7'd31: row = 32'h79591919;
      7'd32: row = 32'h75551515;
      7'd33: row = 32'h6a4a0a0a;
      7'd34: row = 32'h6b4b0b0b;
      7'd35: row = 32'h62420202;
      7'd36: row = 32'h6e4e0e0e;
      7'd37: row = 32'h382a382a;
      7'd38: row = 32'h39283928;
      7'd39: row = 32'h69490909;
      7'd40: row = 32'h6f4f0f0f;
      7'd41: row = 32'h6c4c0c0c;
      7'd42: row = 32'h3b3a3b3a;
      7'd43: row = 32'h6d4d0d0d;
      7'd44: row = 32'h2c3c2c3c;
      7'd45: row = 32'h30293029;
      7'd46: row = 32'h2d5f2d1f;
      7'd47: row = 32'h70501010;
      7'd48: row = 32'h5b7b1b7b;
      7'd49: row = 32'h27222722;
      7'd50: row = 32'h0d0d0d0d;
      7'd51: row = 32'h2e3e2e3e;
      7'd52: row = 32'h2f3f2f3f;
      7'd53: row = 32'h3d2b3d2b;
      7'd54: row = 32'h607e607e;
      7'd55: row = 32'h5d7d1d7d;
      7'd56: row = 32'h5c7c1c7c;
      7'd57: row = 32'hb1b1b1b1;
      7'd58: row = 32'hb0b0b0b0;
      7'd59: row = 32'h0a0a0a0a;
      7'd60: row = 32'h08080808;
      7'd61: row = 32'h7f7f7f7f;
      7'd62: row = 32'hb4b4b4b4;
      7'd63: row = 32'hb2b2b2b2;
      7'd64: row = 32'hb3b3b3b3;
      7'd65: row = 32'haeaeaeae;
      7'd66: row = 32'hb7b7b7b7;
      7'd67: row = 32'hb8b8b8b8;
      7'd68: row = 32'hb5b5b5b5;
      7'd69: row = 32'hb6b6b6b6;
      7'd70: row = 32'h82828282;
      7'd71: row = 32'h81818181;
      7'd72: row = 32'h88888888;
      7'd73: row = 32'h86868686;
      7'd74: row = 32'hb9b9b9b9;
      7'd75: row = 32'hadadadad;
      7'd76: row = 32'hacacacac;
      7'd77: row = 32'h84848484;
      7'd78: row = 32'h83838383;
      7'd79: row = 32'h87878787;
      7'd80: row = 32'h85858585;
      7'd81: row = 32'h8d8d8d8d;
      7'd82: row = 32'h20202020;
      default: row = 32'hffffffff;
    endcase
    return row;
  endfunction

  // Code ROM lookup by key number and column.
  function automatic logic [7:0] code_rom(input logic [6:0] key, input logic [1:0] col);
    logic [31:0] row;
    row = code_row(key);
    unique case (col)
      COL_NORMAL:     return row[31:24];
      COL_SHIFT:      return row[23:16];
      COL_CTRL:       return row[15:8];
      COL_CTRL_SHIFT: return row[7:0];
      default:        return row[31:24];
    endcase
  endfunction

  // Default final letter of each function-key string.
  function automatic logic [7:0] fkey_letter(input logic [2:0] slot);
    unique case (slot)
      3'd0: return 8'h50;
      3'd1: return 8'h51;
      3'd2: return 8'h52;
      3'd3: return 8'h53;
      3'd4: return 8'h41;
      3'd5: return 8'h42;
      3'd6: return 8'h43;
      3'd7: return 8'h44;
      default: return 8'h50;
    endcase
  endfunction

endpackage
`default_nettype wire

### src/kst_fkey_store.sv
`default_nettype none
module kst_fkey_store
  import kst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire kst_rd_req_t rd_req,
  output logic [7:0]       rd_data,
  output logic             init_done
);

  logic [7:0] mem [STORE_DEPTH];

  logic [FKEY_IDX_W:0]   init_key_r, init_key_nxt;
  logic [FKEY_OFS_W-1:0] init_ofs_r, init_ofs_nxt;
  logic                  init_busy_r, init_busy_nxt;
  logic [STORE_AW-1:0]   init_addr;
  logic [7:0]            init_data;
  logic [7:0]            rd_data_r;

  // Sweep the store once after reset, one entry per cycle, with default strings.
  always_comb begin
    init_key_nxt  = init_key_r;
    init_ofs_nxt  = init_ofs_r;
    init_busy_nxt = init_busy_r;
    init_addr     = STORE_AW'(init_key_r) * STORE_AW'(FKEY_MAX_LEN) + STORE_AW'(init_ofs_r);
    if (init_ofs_r == '0) begin
      init_data = ESC_CODE;
    end else if (init_ofs_r == FKEY_OFS_W'(1)) begin
      init_data = fkey_letter(3'(init_key_r));
    end else begin
      init_data = 8'h00;
    end
    if (init_busy_r) begin
      if (init_ofs_r == FKEY_OFS_W'(FKEY_MAX_LEN - 1)) begin
        init_ofs_nxt = '0;
        if (init_key_r == (FKEY_IDX_W + 1)'(NUM_FKEYS - 1)) begin
          init_busy_nxt = 1'b0;
        end else begin
          init_key_nxt = init_key_r + 1'b1;
        end
      end else begin
        init_ofs_nxt = init_ofs_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_key_r  <= '0;
      init_ofs_r  <= '0;
      init_busy_r <= 1'b1;
    end else begin
      init_key_r  <= init_key_nxt;
      init_ofs_r  <= init_ofs_nxt;
      init_busy_r <= init_busy_nxt;
    end
  end

  // Memory with a separate write address for the sweep and a registered read port.
  always_ff @(posedge clk) begin
    if (init_busy_r) begin
      mem[init_addr] <= init_data;
    end
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign init_done = !init_busy_r;

endmodule
`default_nettype wire

### src/keyboard_scancode_translator_core.sv
`default_nettype none
// A plain, break or keypad result passes from the input transaction to the working registers
// (ST_DIRECT), then to the output register; function-key string bytes each take a store read
// (ST_READ), then an output register load (ST_EMIT). One input per cycle is taken if it gives
// no byte; otherwise the next input waits until the run's last byte is loaded for output.
// Reset: synchronous, active low; a sweep of the 64 store entries loads the default strings
// before the first input transaction is taken.
module keyboard_scancode_translator_core
  import kst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_scan_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_char,
  output logic            out_is_break,
  output logic            out_last_of_run,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);

  kst_state_t state_r, state_nxt;

  logic shift_r, shift_nxt;
  logic ctrl_r, ctrl_nxt;
  logic caps_r, caps_nxt;
  logic kp_esc_r;

  logic [FKEY_LEN_W-1:0] fkey_len_r [NUM_FKEYS];

  logic [6:0]            b0_r, b0_nxt;
  logic [6:0]            b1_r, b1_nxt;
  logic                  brk_r, brk_nxt;
  logic [CNT_W-1:0]      tot_r, tot_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [FKEY_IDX_W-1:0] fidx_r, fidx_nxt;

  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       out_brk_r;
  logic       out_last_r;
  logic       out_load;
  logic [6:0] load_char;
  logic       load_brk;
  logic       load_last;
  logic       slot_free;

  kst_rd_req_t rd_req;
  logic [7:0]  rd_data;
  logic        init_done;

  logic                  press;
  logic [6:0]            key;
  logic [1:0]            col;
  logic [7:0]            code;
  logic [6:0]            low;
  logic                  silent;
  logic [FKEY_IDX_W-1:0] idx;
  logic [FKEY_LEN_W-1:0] flen;
  logic [CNT_W-1:0]      flen_cap;
  logic                  is_last;

  kst_fkey_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .init_done (init_done)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign is_last   = (cnt_r == tot_r - 1'b1);

  // Decode of the incoming byte against the updated modifier state.
  always_comb begin
    press     = !in_scan_byte[7];
    key       = in_scan_byte[6:0];
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    caps_nxt  = caps_r;
    if (key == KEY_RSHIFT || key == KEY_LSHIFT) begin
      shift_nxt = press;
    end
    if (key == KEY_CONTROL) begin
      ctrl_nxt = press;
    end
    if (key == KEY_CAPS && !press) begin
      caps_nxt = !caps_r;
    end
    priority if (ctrl_nxt && shift_nxt) begin
      col = COL_CTRL_SHIFT;
    end else if (ctrl_nxt) begin
      col = COL_CTRL;
    end else if (shift_nxt) begin
      col = COL_SHIFT;
    end else begin
      col = COL_NORMAL;
    end
    code = code_rom(key, col);
    if (col == COL_NORMAL && caps_nxt && code >= LOWER_A && code <= LOWER_Z) begin
      code = code - CASE_DIFF;
    end
    low    = code[6:0];
    silent = !press || ({1'b0, key} >= 8'(NUM_KEYS)) || ({1'b0, key} >= 8'(ROM_ROWS))
             || (key >= KEY_SET_UP && key <= KEY_LSHIFT);
    idx    = FKEY_IDX_W'(low - 7'd1);
    flen   = fkey_len_r[idx];
    flen_cap = (32'(flen) > FKEY_CAP) ? CNT_W'(FKEY_CAP) : CNT_W'(flen);
  end

  // Sequencer: next state, transaction bookkeeping and output loads.
  always_comb begin
    state_nxt = state_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    brk_nxt   = brk_r;
    tot_nxt   = tot_r;
    cnt_nxt   = cnt_r;
    fidx_nxt  = fidx_r;
    in_ready  = 1'b0;
    rd_req.en   = 1'b0;
    rd_req.addr = STORE_AW'(fidx_r) * STORE_AW'(FKEY_MAX_LEN) + STORE_AW'(cnt_r);
    out_load  = 1'b0;
    load_char = b0_r;
    load_brk  = brk_r;
    load_last = is_last;
    unique case (state_r)
      ST_INIT: begin
        if (init_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !silent) begin
          cnt_nxt = '0;
          brk_nxt = 1'b0;
          b0_nxt  = low;
          b1_nxt  = low;
          tot_nxt = CNT_W'(1);
          priority if (!code[7]) begin
            state_nxt = ST_DIRECT;
          end else if (code == BREAK_CODE) begin
            b0_nxt    = 7'd0;
            brk_nxt   = 1'b1;
            state_nxt = ST_DIRECT;
          end else if (low >= 7'd1 && 32'(low) <= NUM_FKEYS) begin
            fidx_nxt = idx;
            tot_nxt  = flen_cap;
            if (flen_cap != '0) begin
              state_nxt = ST_READ;
            end
          end else begin
            if (kp_esc_r) begin
              b0_nxt  = ESC_CODE[6:0];
              tot_nxt = CNT_W'(2);
            end
            state_nxt = ST_DIRECT;
          end
        end
      end
      ST_DIRECT: begin
        load_char = (cnt_r == '0) ? b0_r : b1_r;
        if (slot_free) begin
          out_load = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        rd_req.en = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        load_char = rd_data[6:0];
        load_brk  = 1'b0;
        if (slot_free) begin
          out_load  = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = is_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and modifiers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      shift_r  <= 1'b0;
      ctrl_r   <= 1'b0;
      caps_r   <= 1'b0;
      kp_esc_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_FKEYS; i++) begin
        fkey_len_r[i] <= FKEY_DEF_LEN;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_valid) begin
        shift_r <= shift_nxt;
        ctrl_r  <= ctrl_nxt;
        caps_r  <= caps_nxt;
      end
      if (cfg_wr_en) begin
        kp_esc_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and output payload.
  always_ff @(posedge clk) begin
    b0_r   <= b0_nxt;
    b1_r   <= b1_nxt;
    brk_r  <= brk_nxt;
    tot_r  <= tot_nxt;
    cnt_r  <= cnt_nxt;
    fidx_r <= fidx_nxt;
    if (out_load) begin
      out_char_r <= load_char;
      out_brk_r  <= load_brk;
      out_last_r <= load_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_is_break    = out_brk_r;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import kst_pkg::*;
;

  localparam int PHASE_ITEMS   = 88;
  localparam int SETTLE_CYCLES = 40;

  // One emitted byte as seen on the result channel.
  typedef struct packed {
    logic [6:0] ch;
    logic       brk;
    logic       last;
  } key_result_t;

  // Code table by key number: normal, shift, control, control+shift from the top byte down.
  localparam logic [31:0] KEYMAP [0:82] = '{
    32'h80808080, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h1b1b1b1b, 32'h31213121, 32'h09090909, 32'h71511111, 32'h61410101, 32'h73531313,
    32'hffffffff, 32'h32403200, 32'h33233323, 32'h77571717, 32'h65450505, 32'h64440404,
    32'h66460606, 32'h7a5a1a1a, 32'h78581818, 32'h34243424, 32'h35253525, 32'h72521212,
    32'h74541414, 32'h67470707, 32'h68480808, 32'h63430303, 32'h76561616, 32'h365e361e,
    32'h37263726, 32'h79591919, 32'h75551515, 32'h6a4a0a0a, 32'h6b4b0b0b, 32'h62420202,
    32'h6e4e0e0e, 32'h382a382a, 32'h39283928, 32'h69490909, 32'h6f4f0f0f, 32'h6c4c0c0c,
    32'h3b3a3b3a, 32'h6d4d0d0d, 32'h2c3c2c3c, 32'h30293029, 32'h2d5f2d1f, 32'h70501010,
    32'h5b7b1b7b, 32'h27222722, 32'h0d0d0d0d, 32'h2e3e2e3e, 32'h2f3f2f3f, 32'h3d2b3d2b,
    32'h607e607e, 32'h5d7d1d7d, 32'h5c7c1c7c, 32'hb1b1b1b1, 32'hb0b0b0b0, 32'h0a0a0a0a,
    32'h08080808, 32'h7f7f7f7f, 32'hb4b4b4b4, 32'hb2b2b2b2, 32'hb3b3b3b3, 32'haeaeaeae,
    32'hb7b7b7b7, 32'hb8b8b8b8, 32'hb5b5b5b5, 32'hb6b6b6b6, 32'h82828282, 32'h81818181,
    32'h88888888, 32'h86868686, 32'hb9b9b9b9, 32'hadadadad, 32'hacacacac, 32'h84848484,
    32'h83838383, 32'h87878787, 32'h85858585, 32'h8d8d8d8d, 32'h20202020
  };

  // Final letter of each default function-key string.
  localparam logic [7:0] FKEY_TAIL [0:7] = '{
    8'h50, 8'h51, 8'h52, 8'h53, 8'h41, 8'h42, 8'h43, 8'h44
  };

  // Tracks modifier state, predicts the characters of each keystroke and matches them.
  class keystroke_tracker;
    key_result_t pending_chars[$];
    bit          shift_on;
    bit          ctrl_on;
    bit          caps_on;
    bit          keypad_esc;
    int          mismatch_count;

    function void report(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
    endfunction

    // Predicts the characters caused by one accepted scan byte; returns how many.
    function int absorb_scan(logic [7:0] scan);
      logic        press;
      logic [6:0]  key;
      logic [1:0]  col;
      logic [31:0] row;
      logic [7:0]  code;
      logic [6:0]  low;
      key_result_t run[$];
      key_result_t r;

      press = ~scan[7];
      key   = scan[6:0];

      // Modifiers track the byte whatever else it decodes to.
      if (key == KEY_RSHIFT || key == KEY_LSHIFT) begin
        shift_on = press;
      end
      if (key == KEY_CONTROL) begin
        ctrl_on = press;
      end
      if (key == KEY_CAPS && !press) begin
        caps_on = !caps_on;
      end

      if (!press || key >= NUM_KEYS || (key >= KEY_SET_UP && key <= KEY_LSHIFT)) begin
        return 0;
      end

      // Column choice; caps lock only matters with no other modifier.
      if (ctrl_on && shift_on) begin
        col = COL_CTRL_SHIFT;
      end else if (ctrl_on) begin
        col = COL_CTRL;
      end else if (shift_on) begin
        col = COL_SHIFT;
      end else begin
        col = COL_NORMAL;
      end
      row = KEYMAP[key];
      case (col)
        COL_NORMAL:     code = row[31:24];
        COL_SHIFT:      code = row[23:16];
        COL_CTRL:       code = row[15:8];
        default:        code = row[7:0];
      endcase
      if (col == COL_NORMAL && caps_on && code >= LOWER_A && code <= LOWER_Z) begin
        code = code - CASE_DIFF;
      end

      r.last = 1'b0;
      if (code[7] == 1'b0) begin
        r.ch  = code[6:0];
        r.brk = 1'b0;
        run.push_back(r);
      end else if (code == BREAK_CODE) begin
        r.ch  = '0;
        r.brk = 1'b1;
        run.push_back(r);
      end else begin
        low   = code[6:0];
        r.brk = 1'b0;
        if (low >= 1 && low <= NUM_FKEYS) begin
          // Default function-key string: ESC and one letter.
          r.ch = ESC_CODE[6:0];
          run.push_back(r);
          r.ch = FKEY_TAIL[3'(low - 7'd1)][6:0];
          run.push_back(r);
        end else begin
          // Keypad code, with an ESC lead-in in escape mode.
          if (keypad_esc) begin
            r.ch = ESC_CODE[6:0];
            run.push_back(r);
          end
          r.ch = low;
          run.push_back(r);
        end
      end

      run[run.size() - 1].last = 1'b1;
      foreach (run[i]) begin
        pending_chars.push_back(run[i]);
      end
      return run.size();
    endfunction

    // Compares one result transaction with the oldest prediction.
    function void match_char(logic [6:0] ch, logic brk, logic last);
      key_result_t want;

      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected char=%h brk=%b last=%b", ch, brk, last));
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch || brk !== want.brk || last !== want.last) begin
        report($sformatf("char exp=%h got=%h  brk exp=%b got=%b  last exp=%b got=%b",
                         want.ch, ch, want.brk, brk, want.last, last));
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction

    function void close_out();
      if (pending_chars.size() != 0) begin
        report($sformatf("%0d predicted chars never arrived", pending_chars.size()));
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       out_is_break;
  logic       out_last_of_run;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  keystroke_tracker tracker = new;

  keyboard_scancode_translator_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_scan_byte   (in_scan_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_is_break   (out_is_break),
    .out_last_of_run(out_last_of_run),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Result channel monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.match_char(out_char, out_is_break, out_last_of_run);
    end
  end

  // Offers one scan byte and waits for its transaction; starts and ends at a falling edge.
  task automatic send_scan(input logic [7:0] scan, output int produced);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_scan_byte = scan;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    produced = tracker.absorb_scan(scan);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted character has come out.
  task automatic drain_results();
    in_valid = 1'b0;
    while (tracker.outstanding() != 0) begin
      @(negedge clk);
    end
  endtask

  // Keypad escape mode is changed only with the block idle.
  task automatic load_keypad_mode(input bit mode);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = mode;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tracker.keypad_esc = mode;
  endtask

  // Mostly real keystrokes, with modifier traffic, releases and raw noise mixed in.
  function automatic logic [7:0] pick_scan();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) begin
      return {1'b0, 7'($urandom_range(NUM_KEYS - 1))};
    end else if (roll < 72) begin
      return {1'($urandom_range(1)), 7'($urandom_range(KEY_LSHIFT, KEY_CONTROL))};
    end else if (roll < 86) begin
      return {1'b1, 7'($urandom_range(127))};
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic run_phase(input int send_pct, input int recv_pct, input bit mode,
                           input bit hold_midway);
    int made;
    int got;
    bit held;

    made = 0;
    held = 1'b0;
    load_keypad_mode(mode);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (made < PHASE_ITEMS) begin
      if (hold_midway && !held && made >= PHASE_ITEMS / 2) begin
        drain_results();
        held = 1'b1;
      end
      send_scan(pick_scan(), got);
      made++;
    end
  endtask

  // Directed keystrokes with escape mode off: bounds, modifiers, caps lock, strings.
  localparam logic [7:0] OPENING_KEYS [0:23] = '{
    8'h00, 8'hff, 8'h7f, 8'h53, 8'h52, 8'h01, 8'h09, 8'h03,
    8'h83, 8'h09, 8'h07, 8'h04, 8'h0d, 8'h85, 8'h0d, 8'h02,
    8'h0d, 8'h05, 8'h0d, 8'h1d, 8'h82, 8'h47, 8'h48, 8'h39
  };

  // Directed keystrokes with escape mode on: keypad, no-scroll, break and a string.
  localparam logic [7:0] KEYPAD_KEYS [0:3] = '{8'h0c, 8'h51, 8'h00, 8'h4f};

  initial begin
    int got;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    load_keypad_mode(1'b0);
    foreach (OPENING_KEYS[i]) begin
      send_scan(OPENING_KEYS[i], got);
    end
    load_keypad_mode(1'b1);
    foreach (KEYPAD_KEYS[i]) begin
      send_scan(KEYPAD_KEYS[i], got);
    end

    run_phase(0, 0, 1'b0, 1'b0);
    run_phase(74, 0, 1'b1, 1'b1);
    run_phase(0, 74, 1'b0, 1'b0);
    run_phase(17, 17, 1'b1, 1'b0);

    // Let the last strings drain, then allow for trailing activity.
    in_valid = 1'b0;
    for (int w = 0; w < 20000 && tracker.outstanding() != 0; w++) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    tracker.close_out();

    if (tracker.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
